/* rtl/prb_pkg.sv */
package prb_pkg;

  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned LEN_W   = 9;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_REJ = 1'b1;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             alpha_given;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic [7:0]       out_alpha;
    logic [LEN_W-1:0] palette_len;
    logic [LEN_W-1:0] transparency_len;
  } out_item_t;

endpackage

/* rtl/prb_serdiv.sv */
// Bit-serial restoring divider: 18-bit numerator by 9-bit divisor, one
// quotient bit per cycle. Only the low 8 quotient bits are returned.
module prb_serdiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [17:0] num,
  input  logic [8:0]  den,
  output logic        done,
  output logic [7:0]  quo
);
  import prb_pkg::*;

  logic [17:0] q_r, q_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [8:0]  den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [9:0]  trial;
  logic [10:0] diff;

  assign trial = {rem_r[8:0], q_r[17]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};

  // Shift one numerator bit in, subtract when it fits
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      q_nxt   = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = 5'd0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[10]) begin
        rem_nxt = diff[9:0];
        q_nxt   = {q_r[16:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[16:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd17) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = q_r[7:0];
endmodule

/* rtl/palette_ramp_builder.sv */
// Channel   | Direction | Handshake
// in_*      | input     | start && !busy accepts one transaction
// out_*     | output    | out_valid marks one cycle, always taken
//
// A read, or an add with no fill, goes on to the scan; an add filling n entries
// uses a single bit-serial divider, shared by the four channels in turn, for each
// entry, then the transparency scan walks down from the last key, entry by entry.
// Clear is a clearing pass that writes all ENTRIES entries, followed by the scan.
// Reset runs the same clearing pass; busy is high during it.
// The receiver cannot stall: results are shown for one cycle.
module palette_ramp_builder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  prb_pkg::in_item_t    in_item,
  output logic                 out_valid,
  output prb_pkg::out_item_t   out_item
);
  import prb_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_RDW   = 4'd3;
  localparam logic [3:0] S_PRD   = 4'd4;
  localparam logic [3:0] S_PRDW  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_SCANW = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [31:0] mem [ENTRIES];
  logic [31:0] rdata_r;
  logic        we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [31:0] wdata;

  logic [3:0]       st_r, st_nxt;
  in_item_t         it_r, it_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic [31:0]      a_r, a_nxt;
  logic [31:0]      e_r, e_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [LEN_W-1:0] sc_r, sc_nxt;
  logic [LEN_W-1:0] cl_r, cl_nxt;
  logic             status_r, status_nxt;
  logic [31:0]      rd_r, rd_nxt;
  logic             dgo;
  logic             ddone;
  logic [7:0]       dquo;
  logic [17:0]      dnum;
  logic [8:0]       dden;
  logic [31:0]      key;
  logic [IDX_W-1:0] dd, tt;
  logic [7:0]       ca, cb;
  logic [16:0]      sum;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign key = {(it_r.alpha_given ? it_r.alpha : 8'hff), it_r.blue, it_r.green, it_r.red};
  assign dd  = it_r.index - last_r;
  assign tt  = j_r - last_r;
  assign ca  = a_r[8*ch_r +: 8];
  assign cb  = key[8*ch_r +: 8];
  // numerator 2*(a*(d-t)+b*t)+d, one numerator per channel step
  assign sum  = 17'(ca * (dd - tt)) + 17'(cb * tt);
  assign dnum = {sum, 1'b0} + 18'(dd);
  assign dden = {dd, 1'b0};

  prb_serdiv u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  // Sequence one transaction through memory, the divider (on adds) and the scan
  always_comb begin
    st_nxt = st_r; it_nxt = it_r; last_nxt = last_r; a_nxt = a_r; e_nxt = e_r;
    j_nxt = j_r; ch_nxt = ch_r; sc_nxt = sc_r; cl_nxt = cl_r;
    status_nxt = status_r; rd_nxt = rd_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = j_r; dgo = 1'b0;
    unique case (st_r)
      S_CLR: begin
        we = 1'b1; waddr = cl_r[IDX_W-1:0];
        cl_nxt = cl_r + 9'd1;
        if (cl_r == LEN_W'(ENTRIES - 1)) st_nxt = it_r.op == OP_CLEAR ? S_SCAN : S_IDLE;
        sc_nxt = 9'd1;
      end
      S_IDLE: begin
        if (start) begin
          it_nxt = in_item; status_nxt = ST_OK; rd_nxt = '0;
          unique case (in_item.op)
            OP_ADD: begin
              if (in_item.index <= last_r && !(last_r == '0 && in_item.index == '0)) begin
                status_nxt = ST_REJ; st_nxt = S_SCAN;
              end else st_nxt = S_PRD;
              sc_nxt = {1'b0, last_r} + 9'd1;
            end
            OP_READ: begin
              st_nxt = S_RD; j_nxt = in_item.index;
            end
            OP_CLEAR: begin
              st_nxt = S_CLR; cl_nxt = '0; last_nxt = '0;
            end
            default: begin
              st_nxt = S_SCAN; sc_nxt = {1'b0, last_r} + 9'd1;
            end
          endcase
        end
      end
      S_RD: begin raddr = j_r; st_nxt = S_RDW; end
      S_RDW: begin
        rd_nxt = rdata_r; st_nxt = S_SCAN; sc_nxt = {1'b0, last_r} + 9'd1;
      end
      S_PRD: begin raddr = last_r; st_nxt = S_PRDW; end
      S_PRDW: begin
        a_nxt = rdata_r; we = 1'b1; waddr = it_r.index; wdata = key;
        j_nxt = last_r + 8'd1; ch_nxt = '0;
        if (it_r.index == last_r || last_r + 8'd1 == it_r.index) st_nxt = S_WR;
        else st_nxt = S_DIV;
      end
      S_DIV: begin dgo = 1'b1; st_nxt = S_DIVW; end
      S_DIVW: begin
        if (ddone) begin
          e_nxt[8*ch_r +: 8] = dquo;
          ch_nxt = ch_r + 2'd1;
          st_nxt = S_DIV;
          if (ch_r == 2'd3) begin
            we = 1'b1; waddr = j_r;
            wdata = {dquo, e_r[23:0]};
            j_nxt = j_r + 8'd1;
            if (j_r + 8'd1 == it_r.index) st_nxt = S_WR;
          end
        end
      end
      S_WR: begin
        last_nxt = it_r.index; sc_nxt = {1'b0, it_r.index} + 9'd1; st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sc_r == '0) st_nxt = S_DONE;
        else begin raddr = 8'(sc_r - 9'd1); st_nxt = S_SCANW; end
      end
      S_SCANW: begin
        if (rdata_r[31:24] == 8'hff) begin sc_nxt = sc_r - 9'd1; st_nxt = S_SCAN; end
        else st_nxt = S_DONE;
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; cl_r <= '0; last_r <= '0; it_r.op <= OP_READ;
    end else begin
      st_r <= st_nxt; cl_r <= cl_nxt; last_r <= last_nxt; it_r.op <= it_nxt.op;
    end
    it_r.index <= it_nxt.index; it_r.red <= it_nxt.red; it_r.green <= it_nxt.green;
    it_r.blue <= it_nxt.blue; it_r.alpha <= it_nxt.alpha;
    it_r.alpha_given <= it_nxt.alpha_given;
    a_r <= a_nxt; e_r <= e_nxt; j_r <= j_nxt; ch_r <= ch_nxt; sc_r <= sc_nxt;
    status_r <= status_nxt; rd_r <= rd_nxt;
  end

  assign busy      = st_r != S_IDLE;
  assign out_valid = st_r == S_DONE;
  assign out_item.status           = status_r;
  assign out_item.out_red          = rd_r[7:0];
  assign out_item.out_green        = rd_r[15:8];
  assign out_item.out_blue         = rd_r[23:16];
  assign out_item.out_alpha        = rd_r[31:24];
  assign out_item.palette_len      = {1'b0, last_r} + 9'd1;
  assign out_item.transparency_len = sc_r;
endmodule
